// ===== src/grid_neighbor_list_generator_core_macros.svh =====
// assertion macros for the grid neighbor list generator
`ifndef GRID_NEIGHBOR_LIST_GENERATOR_CORE_MACROS_SVH
`define GRID_NEIGHBOR_LIST_GENERATOR_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define GNL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("gnl assertion failed");
`define GNL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("gnl assertion failed");
`else
`define GNL_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define GNL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/gnl_pkg.sv =====
// shared types, constants and microcode program of the neighbor list generator
package gnl_pkg;

	localparam int MAX_ISLANDS = 1024;
	localparam int ISL_AW      = $clog2(MAX_ISLANDS);
	localparam int IC_W        = 11;
	localparam int GRP_W       = 10;
	localparam int TOPO_W      = 3;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 11;
	localparam int ADDR_W      = IC_W + 1;
	localparam int PROD_W      = 2 * IC_W;
	localparam int DIV_CNT_W   = $clog2(GRP_W + 1);
	localparam int STEP_W      = 5;

	localparam logic [CFG_IDX_W-1:0] REG_ISLAND_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TOPOLOGY     = 2'd2;

	localparam logic [IC_W-1:0]   RST_ISLAND_COUNT = 11'd1024;
	localparam logic [IC_W-1:0]   RST_ROW_LENGTH   = 11'd32;

	localparam logic [TOPO_W-1:0] TOPO_LINEAR = 3'd0;
	localparam logic [TOPO_W-1:0] TOPO_THREE  = 3'd1;
	localparam logic [TOPO_W-1:0] TOPO_SQUARE = 3'd2;
	localparam logic [TOPO_W-1:0] TOPO_HEX    = 3'd3;
	localparam logic [TOPO_W-1:0] TOPO_OCTAL  = 3'd4;
	localparam logic [TOPO_W-1:0] TOPO_RANDOM = 3'd5;
	localparam logic [TOPO_W-1:0] TOPO_POOL   = 3'd6;
	localparam logic [TOPO_W-1:0] TOPO_FLOAT  = 3'd7;

	localparam logic OP_QUERY = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	typedef logic [STEP_W-1:0] step_t;

	localparam step_t ST_IDLE     = 5'd0;
	localparam step_t ST_CLASSIFY = 5'd1;
	localparam step_t ST_DIV      = 5'd2;
	localparam step_t ST_MUL      = 5'd3;
	localparam step_t ST_LIN      = 5'd4;
	localparam step_t ST_SQR      = 5'd6;
	localparam step_t ST_HEX      = 5'd11;
	localparam step_t ST_OCT      = 5'd20;
	localparam step_t ST_DRAIN    = 5'd29;
	localparam step_t ST_FIN      = 5'd30;

	typedef enum logic [2:0] {
		JMP_NEXT, JMP_GOTO, JMP_IN, JMP_GRID, JMP_DIV, JMP_TOPO, JMP_OUT
	} jmp_t;

	typedef enum logic [2:0] {
		ACT_NONE, ACT_IDLE, ACT_CLASSIFY, ACT_MUL, ACT_PROBE, ACT_FINISH
	} act_t;

	typedef enum logic [2:0] {
		NB_LEFT, NB_RIGHT, NB_UP, NB_UPR, NB_UPL, NB_DOWN, NB_DOWNR, NB_DOWNL
	} nb_t;

	// required conditions of one probe, all must hold
	typedef struct packed {
		logic colpos;
		logic colr;
		logic rowpos;
		logic rowlt;
		logic rowge;
		logic odd;
		logic even;
		logic gpos;
		logic glast;
	} cond_t;

	localparam cond_t C_COLPOS = '{colpos: 1'b1, default: 1'b0};
	localparam cond_t C_COLR   = '{colr: 1'b1, default: 1'b0};
	localparam cond_t C_ROWPOS = '{rowpos: 1'b1, default: 1'b0};
	localparam cond_t C_ROWLT  = '{rowlt: 1'b1, default: 1'b0};
	localparam cond_t C_ROWGE  = '{rowge: 1'b1, default: 1'b0};
	localparam cond_t C_ODD    = '{odd: 1'b1, default: 1'b0};
	localparam cond_t C_EVEN   = '{even: 1'b1, default: 1'b0};
	localparam cond_t C_GPOS   = '{gpos: 1'b1, default: 1'b0};
	localparam cond_t C_GLAST  = '{glast: 1'b1, default: 1'b0};

	typedef struct packed {
		jmp_t  jmp;
		step_t target;
		act_t  act;
		nb_t   nb;
		cond_t cond;
	} uword_t;

	typedef struct packed {
		logic              query_acc;
		logic              grid;
		logic              div_busy;
		logic              stall;
		logic              out_free;
		logic              clearing;
		logic [TOPO_W-1:0] topo;
	} stat_t;

	function automatic uword_t uctl(input jmp_t j, input step_t t, input act_t a);
		uword_t w;
		w.jmp    = j;
		w.target = t;
		w.act    = a;
		w.nb     = NB_LEFT;
		w.cond   = '0;
		return w;
	endfunction

	function automatic uword_t uprobe(input nb_t nb, input cond_t cnd, input logic to_drain);
		uword_t w;
		w.jmp    = to_drain ? JMP_GOTO : JMP_NEXT;
		w.target = ST_DRAIN;
		w.act    = ACT_PROBE;
		w.nb     = nb;
		w.cond   = cnd;
		return w;
	endfunction

	// control store
	function automatic uword_t ucode(input step_t s);
		uword_t w;
		w = uctl(JMP_GOTO, ST_IDLE, ACT_NONE);
		case (s)
			ST_IDLE:                 w = uctl(JMP_IN, ST_CLASSIFY, ACT_IDLE);
			ST_CLASSIFY:             w = uctl(JMP_GRID, ST_FIN, ACT_CLASSIFY);
			ST_DIV:                  w = uctl(JMP_DIV, ST_DIV, ACT_NONE);
			ST_MUL:                  w = uctl(JMP_TOPO, ST_DRAIN, ACT_MUL);
			// linear
			ST_LIN:                  w = uprobe(NB_LEFT, C_GPOS, 1'b0);
			ST_LIN + step_t'(1):     w = uprobe(NB_RIGHT, C_GLAST, 1'b1);
			// square and three-neighbor
			ST_SQR:                  w = uprobe(NB_LEFT, C_COLPOS, 1'b0);
			ST_SQR + step_t'(1):     w = uprobe(NB_UP, C_ROWPOS, 1'b0);
			ST_SQR + step_t'(2):     w = uprobe(NB_DOWN, C_ROWLT, 1'b0);
			ST_SQR + step_t'(3):     w = uprobe(NB_RIGHT, C_ROWLT | C_COLR, 1'b0);
			ST_SQR + step_t'(4):     w = uprobe(NB_RIGHT, C_ROWGE | C_GLAST, 1'b1);
			// honeycomb
			ST_HEX:                  w = uprobe(NB_LEFT, C_COLPOS, 1'b0);
			ST_HEX + step_t'(1):     w = uprobe(NB_UP, C_ROWPOS, 1'b0);
			ST_HEX + step_t'(2):     w = uprobe(NB_UPR, C_ROWPOS | C_ODD | C_COLR, 1'b0);
			ST_HEX + step_t'(3):     w = uprobe(NB_UPL, C_ROWPOS | C_EVEN | C_COLPOS, 1'b0);
			ST_HEX + step_t'(4):     w = uprobe(NB_DOWN, C_ROWLT, 1'b0);
			ST_HEX + step_t'(5):     w = uprobe(NB_RIGHT, C_ROWLT | C_COLR, 1'b0);
			ST_HEX + step_t'(6):     w = uprobe(NB_DOWNR, C_ROWLT | C_ODD | C_COLR, 1'b0);
			ST_HEX + step_t'(7):     w = uprobe(NB_DOWNL, C_ROWLT | C_EVEN | C_COLPOS, 1'b0);
			ST_HEX + step_t'(8):     w = uprobe(NB_RIGHT, C_ROWGE | C_GLAST, 1'b1);
			// eight-neighbor
			ST_OCT:                  w = uprobe(NB_LEFT, C_COLPOS, 1'b0);
			ST_OCT + step_t'(1):     w = uprobe(NB_UP, C_ROWPOS, 1'b0);
			ST_OCT + step_t'(2):     w = uprobe(NB_UPR, C_ROWPOS | C_COLR, 1'b0);
			ST_OCT + step_t'(3):     w = uprobe(NB_UPL, C_ROWPOS | C_COLPOS, 1'b0);
			ST_OCT + step_t'(4):     w = uprobe(NB_DOWN, C_ROWLT, 1'b0);
			ST_OCT + step_t'(5):     w = uprobe(NB_RIGHT, C_ROWLT | C_COLR, 1'b0);
			ST_OCT + step_t'(6):     w = uprobe(NB_DOWNR, C_ROWLT | C_COLR, 1'b0);
			ST_OCT + step_t'(7):     w = uprobe(NB_DOWNL, C_ROWLT | C_COLPOS, 1'b0);
			ST_OCT + step_t'(8):     w = uprobe(NB_RIGHT, C_ROWGE | C_GLAST, 1'b1);
			ST_DRAIN:                w = uctl(JMP_NEXT, ST_FIN, ACT_NONE);
			ST_FIN:                  w = uctl(JMP_OUT, ST_IDLE, ACT_FINISH);
			default:                 w = uctl(JMP_GOTO, ST_IDLE, ACT_NONE);
		endcase
		return w;
	endfunction

endpackage

// ===== src/gnl_if.sv =====
// valid/ready channel interfaces for query/write items and neighbor results
interface gnl_in_if;
	import gnl_pkg::*;
	logic             valid;
	logic             ready;
	logic             operation;
	logic [GRP_W-1:0] group;
	logic             occupied;
	logic [GRP_W-1:0] random_pick;

	modport source (output valid, operation, group, occupied, random_pick, input ready);
	modport sink (input valid, operation, group, occupied, random_pick, output ready);
endinterface

interface gnl_out_if;
	import gnl_pkg::*;
	logic            valid;
	logic            ready;
	logic [IC_W-1:0] neighbor;
	logic            none_found;
	logic            is_last;

	modport source (output valid, neighbor, none_found, is_last, input ready);
	modport sink (input valid, neighbor, none_found, is_last, output ready);
endinterface

// ===== src/grid_neighbor_list_generator_core.sv =====
// Grid neighbor list generator. Keeps one occupancy bit per island in a 1024 x 1 map and
// answers neighbor queries for the configured topology. After reset the map is cleared in a
// pass during which in_ch.ready stays low; configuration writes are taken at any time.
// A write item gives no result. A query for the random, pool or floating topology, or with
// at most two islands, skips the divider and the probes. A grid query runs the probe steps
// of its topology (2 linear, 5 square and three-neighbor, 9 honeycomb and eight-neighbor)
// after the restoring divider that finds row and column; the single read port of the map
// takes one probe per cycle while no result waits.
// Output back-pressure holds the probe sequence while a result waits.
`include "grid_neighbor_list_generator_core_macros.svh"
module grid_neighbor_list_generator_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [gnl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gnl_pkg::CFG_DATA_W-1:0] cfg_wdata,
	gnl_in_if.sink                         in_ch,
	gnl_out_if.source                      out_ch
);
	import gnl_pkg::*;

	uword_t uw;
	stat_t  stat;
	step_t  step;

	gnl_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.uw     (uw),
		.step   (step)
	);

	gnl_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.uw        (uw),
		.stat      (stat)
	);

	`GNL_ASSERT_IMPL(a_clear_blocks_input, clk, arst_n, stat.clearing, !in_ch.ready)
	`GNL_ASSERT_NEXT(a_query_classifies, clk, arst_n, in_ch.valid && in_ch.ready && in_ch.operation == OP_QUERY, step == ST_CLASSIFY)
	`GNL_ASSERT_IMPL(a_div_only_in_div_step, clk, arst_n, stat.div_busy, step == ST_DIV)
	`GNL_ASSERT_IMPL(a_empty_result_form, clk, arst_n, out_ch.valid && out_ch.none_found, out_ch.neighbor == '0 && out_ch.is_last)
endmodule

// ===== src/gnl_ram.sv =====
// generic simple dual-port ram with registered read
module gnl_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== src/gnl_div.sv =====
// restoring divider, one quotient bit per cycle, gives row and column of a group
module gnl_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [gnl_pkg::GRP_W-1:0] dividend,
	input  logic [gnl_pkg::IC_W-1:0]  divisor,
	output logic                      busy,
	output logic [gnl_pkg::GRP_W-1:0] quot,
	output logic [gnl_pkg::IC_W-1:0]  rem
);
	import gnl_pkg::*;

	logic [IC_W-1:0]      rem_q;
	logic [GRP_W-1:0]     quo_q;
	logic [IC_W-1:0]      dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic [IC_W:0]        trial;
	logic [IC_W:0]        diff;
	logic                 ge;

	assign trial = {rem_q, quo_q[GRP_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_CNT_W'(GRP_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - DIV_CNT_W'(1);
			if (cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[IC_W-1:0] : trial[IC_W-1:0];
			quo_q <= {quo_q[GRP_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quot = quo_q;
	assign rem  = rem_q;
endmodule

// ===== src/gnl_useq.sv =====
// microcode sequencer: step counter, control store and jump logic
module gnl_useq (
	input  logic            clk,
	input  logic            arst_n,
	input  gnl_pkg::stat_t  stat,
	output gnl_pkg::uword_t uw,
	output gnl_pkg::step_t  step
);
	import gnl_pkg::*;

	step_t step_q;
	step_t step_d;

	assign uw   = ucode(step_q);
	assign step = step_q;

	always_comb begin
		step_d = step_q;
		if (!stat.stall) begin
			unique case (uw.jmp)
				JMP_NEXT: step_d = step_q + step_t'(1);
				JMP_GOTO: step_d = uw.target;
				JMP_IN: begin
					if (stat.query_acc) begin
						step_d = uw.target;
					end
				end
				JMP_GRID: step_d = stat.grid ? step_q + step_t'(1) : uw.target;
				JMP_DIV: begin
					if (!stat.div_busy) begin
						step_d = step_q + step_t'(1);
					end
				end
				JMP_TOPO: begin
					unique case (stat.topo) inside
						TOPO_LINEAR:             step_d = ST_LIN;
						TOPO_THREE, TOPO_SQUARE: step_d = ST_SQR;
						TOPO_HEX:                step_d = ST_HEX;
						TOPO_OCTAL:              step_d = ST_OCT;
						default:                 step_d = uw.target;
					endcase
				end
				JMP_OUT: begin
					if (stat.out_free) begin
						step_d = uw.target;
					end
				end
				default: step_d = ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
		end else begin
			step_q <= step_d;
		end
	end
endmodule

// ===== src/gnl_dp.sv =====
// datapath: registers, occupancy map, divider, neighbor probes and result register
module gnl_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [gnl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gnl_pkg::CFG_DATA_W-1:0] cfg_wdata,
	gnl_in_if.sink                        in_ch,
	gnl_out_if.source                     out_ch,
	input  gnl_pkg::uword_t               uw,
	output gnl_pkg::stat_t                stat
);
	import gnl_pkg::*;

	// configuration
	logic [IC_W-1:0]   ic_q;
	logic [IC_W-1:0]   rl_q;
	logic [TOPO_W-1:0] topo_q;
	logic [IC_W-1:0]   ic_eff;
	logic              ic_is2;
	logic              ic_gt2;
	logic [IC_W-1:0]   rl_new;
	logic [IC_W-1:0]   rl_div;
	logic              grid;

	// query state
	logic [GRP_W-1:0]  g_q;
	logic [GRP_W-1:0]  pick_q;
	logic [IC_W-1:0]   rlw_q;
	logic [IC_W-1:0]   pick_adj;
	logic [PROD_W-1:0] prod_q;
	logic [GRP_W-1:0]  row;
	logic [IC_W-1:0]   col;
	logic              div_busy;
	logic              div_start;

	// probe and take stage
	cond_t             have;
	logic              cond_ok;
	logic [ADDR_W-1:0] g_x;
	logic [ADDR_W-1:0] r_x;
	logic [ADDR_W-1:0] probe_addr;
	logic              in_range;
	logic              s1_valid_q;
	logic [ADDR_W-1:0] s1_addr_q;
	logic [0:0]        rdata;
	logic              hit;
	logic              stall;
	logic              out_free;
	logic [IC_W-1:0]   pend_q;
	logic              pv_q;

	// map clearing and writes
	logic              clearing_q;
	logic [ISL_AW-1:0] clr_q;
	logic              in_acc;
	logic              ram_we;
	logic [ISL_AW-1:0] ram_waddr;
	logic [0:0]        ram_wdata;
	logic [ISL_AW-1:0] ram_raddr;

	// result register
	logic              out_valid_q;
	logic [IC_W-1:0]   out_nb_q;
	logic              out_none_q;
	logic              out_last_q;
	logic              load_mid;
	logic              load_fin;

	assign ic_eff   = (ic_q == '0) ? IC_W'(1) : ic_q;
	assign ic_is2   = ic_eff == IC_W'(2);
	assign ic_gt2   = ic_eff > IC_W'(2);
	assign rl_new   = (topo_q == TOPO_THREE) ? (ic_eff >> 1) : rl_q;
	assign rl_div   = (rl_new == '0) ? IC_W'(1) : rl_new;
	assign grid     = ic_gt2 && (topo_q <= TOPO_OCTAL);
	assign pick_adj = IC_W'(pick_q) + IC_W'(pick_q >= g_q);

	assign in_ch.ready = (uw.act == ACT_IDLE) && !clearing_q;
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign div_start   = (uw.act == ACT_CLASSIFY) && grid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ic_q   <= RST_ISLAND_COUNT;
			rl_q   <= RST_ROW_LENGTH;
			topo_q <= TOPO_SQUARE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ISLAND_COUNT: ic_q   <= cfg_wdata[IC_W-1:0];
				REG_ROW_LENGTH:   rl_q   <= cfg_wdata[IC_W-1:0];
				REG_TOPOLOGY:     topo_q <= cfg_wdata[TOPO_W-1:0];
				default:          ;
			endcase
		end else if (uw.act == ACT_CLASSIFY && ic_gt2 && topo_q == TOPO_THREE) begin
			// three-neighbor query rewrites the row length for good
			rl_q <= ic_eff >> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			g_q    <= in_ch.group;
			pick_q <= in_ch.random_pick;
		end
		if (uw.act == ACT_CLASSIFY) begin
			rlw_q <= rl_div;
		end
		if (uw.act == ACT_MUL) begin
			prod_q <= PROD_W'(IC_W'(row) + IC_W'(2)) * PROD_W'(rlw_q);
		end
	end

	gnl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (g_q),
		.divisor  (rl_div),
		.busy     (div_busy),
		.quot     (row),
		.rem      (col)
	);

	// row < last row bound is (row + 2) * rl <= ic - 1
	always_comb begin
		have        = '0;
		have.colpos = col != '0;
		have.colr   = (ADDR_W'(col) + ADDR_W'(1)) < ADDR_W'(rlw_q);
		have.rowpos = row != '0;
		have.rowlt  = prod_q <= PROD_W'(ic_eff - IC_W'(1));
		have.rowge  = !have.rowlt;
		have.odd    = row[0];
		have.even   = !row[0];
		have.gpos   = g_q != '0;
		have.glast  = (IC_W'(g_q) + IC_W'(1)) < ic_eff;
	end

	assign cond_ok = &(~uw.cond | have);
	assign g_x     = ADDR_W'(g_q);
	assign r_x     = ADDR_W'(rlw_q);

	always_comb begin
		unique case (uw.nb)
			NB_LEFT:  probe_addr = g_x - ADDR_W'(1);
			NB_RIGHT: probe_addr = g_x + ADDR_W'(1);
			NB_UP:    probe_addr = g_x - r_x;
			NB_UPR:   probe_addr = g_x - r_x + ADDR_W'(1);
			NB_UPL:   probe_addr = g_x - r_x - ADDR_W'(1);
			NB_DOWN:  probe_addr = g_x + r_x;
			NB_DOWNR: probe_addr = g_x + r_x + ADDR_W'(1);
			NB_DOWNL: probe_addr = g_x + r_x - ADDR_W'(1);
			default:  probe_addr = g_x;
		endcase
	end

	assign in_range = probe_addr < ADDR_W'(MAX_ISLANDS);
	assign hit      = s1_valid_q && rdata[0];
	assign out_free = !out_valid_q || out_ch.ready;
	assign stall    = hit && pv_q && !out_free;

	// on a stall the held probe is read again so its data is there when it resumes
	assign ram_raddr = stall ? s1_addr_q[ISL_AW-1:0] : probe_addr[ISL_AW-1:0];
	assign ram_we    = clearing_q ||
		(in_acc && in_ch.operation == OP_WRITE &&
		 ADDR_W'(in_ch.group) < ADDR_W'(MAX_ISLANDS));
	assign ram_waddr = clearing_q ? clr_q : in_ch.group[ISL_AW-1:0];
	assign ram_wdata = clearing_q ? 1'b0 : in_ch.occupied;

	gnl_ram #(
		.WIDTH (1),
		.DEPTH (MAX_ISLANDS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (clearing_q) begin
			clr_q <= clr_q + ISL_AW'(1);
			if (clr_q == ISL_AW'(MAX_ISLANDS - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (!stall) begin
			s1_valid_q <= (uw.act == ACT_PROBE) && cond_ok && in_range;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			s1_addr_q <= probe_addr;
		end
	end

	assign load_mid = hit && !stall && pv_q;
	assign load_fin = (uw.act == ACT_FINISH) && out_free;

	// pending neighbor: held back until it is known whether it is the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q <= 1'b0;
		end else if (uw.act == ACT_CLASSIFY) begin
			pv_q <= ic_is2 || (ic_gt2 && (topo_q == TOPO_RANDOM || topo_q == TOPO_POOL));
		end else if (hit && !stall) begin
			pv_q <= 1'b1;
		end else if (load_fin) begin
			pv_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (uw.act == ACT_CLASSIFY) begin
			if (ic_is2) begin
				pend_q <= IC_W'(1) - IC_W'(g_q);
			end else if (topo_q == TOPO_RANDOM) begin
				pend_q <= pick_adj;
			end else begin
				pend_q <= ic_eff;
			end
		end else if (hit && !stall) begin
			pend_q <= s1_addr_q[IC_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_mid || load_fin) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_mid) begin
			out_nb_q   <= pend_q;
			out_none_q <= 1'b0;
			out_last_q <= 1'b0;
		end else if (load_fin) begin
			out_nb_q   <= pv_q ? pend_q : '0;
			out_none_q <= !pv_q;
			out_last_q <= 1'b1;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.neighbor   = out_nb_q;
	assign out_ch.none_found = out_none_q;
	assign out_ch.is_last    = out_last_q;

	assign stat.query_acc = in_acc && in_ch.operation == OP_QUERY;
	assign stat.grid      = grid;
	assign stat.div_busy  = div_busy;
	assign stat.stall     = stall;
	assign stat.out_free  = out_free;
	assign stat.clearing  = clearing_q;
	assign stat.topo      = topo_q;
endmodule
